/* sv/sbpm_pkg.sv */
// Shared types, codes and constants of the servo bus packet master.
`default_nettype none

package sbpm_pkg;

	localparam logic [2:0] CMD_LED    = 3'd0;
	localparam logic [2:0] CMD_MOVE   = 3'd1;
	localparam logic [2:0] CMD_TORQUE = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_RX     = 3'd4;
	localparam logic [2:0] CMD_TICK   = 3'd5;

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	localparam logic [7:0] START_BYTE  = 8'hFF;
	localparam logic [7:0] INSTR_WRITE = 8'd3;
	localparam logic [7:0] INSTR_READ  = 8'd2;
	localparam logic [7:0] REG_LED     = 8'd25;
	localparam logic [7:0] REG_TORQUE  = 8'd24;
	localparam logic [7:0] REG_GOAL    = 8'd30;
	localparam logic [7:0] REG_PRESENT = 8'd36;
	localparam logic [7:0] LEN_SHORT   = 8'd4;
	localparam logic [7:0] LEN_MOVE    = 8'd7;
	localparam logic [7:0] READ_SIZE   = 8'd2;

	localparam int PKT_IDX_W = 4;
	localparam logic [PKT_IDX_W-1:0] PKT_SHORT_LAST = 4'd7;
	localparam logic [PKT_IDX_W-1:0] PKT_MOVE_LAST  = 4'd10;

	localparam logic [7:0] TIMEOUT_RESET   = 8'd50;
	localparam int         WRITE_REPLY_LEN = 5;
	localparam int         READ_REPLY_LEN  = 8;
	localparam int         REPLY_STORE_DEPTH_DEF = 8;
	localparam logic [8:0] TICK_MAX = 9'd511;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  servo_id;
		logic [15:0] target_position;
		logic [15:0] move_speed;
		logic [7:0]  state_value;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  tx_byte;
		logic        last_byte;
		logic        reply_status;
		logic [7:0]  error_byte;
		logic [15:0] present_position;
	} result_t;

	typedef struct packed {
		logic start;
		logic is_read;
		logic rx_en;
		logic tick_en;
	} rep_ctl_t;

	typedef struct packed {
		logic        report;
		logic        status;
		logic [7:0]  error_byte;
		logic [15:0] present_position;
	} rep_res_t;

endpackage

`default_nettype wire

/* sv/servo_bus_packet_master.sv */
// Top level of the servo bus packet master: item register, result register, control.
`default_nettype none

// Each accepted command (set LED, set torque, read position) yields eight transmit words
// and a move yields eleven, one word per cycle out of the result register under no output
// stall. Received-byte and tick items give at most one completion report. The next item
// is taken in the cycle that the current one gives its last word, and that word enters the
// result register at the same edge as the new item enters the item register. cfg_ready is
// always high; the timeout register is to be written only while the block is idle, and the
// block itself does not enforce it.

module servo_bus_packet_master
	import sbpm_pkg::*;
#(
	parameter int REPLY_STORE_DEPTH = REPLY_STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  servo_id,
	input  logic [15:0] target_position,
	input  logic [15:0] move_speed,
	input  logic [7:0]  state_value,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	output logic        reply_status,
	output logic [7:0]  error_byte,
	output logic [15:0] present_position,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  timeout_ms
);

	item_t                item_q;
	logic                 item_valid_q;
	logic [PKT_IDX_W-1:0] idx_q;
	result_t              res_q;
	logic                 out_valid_q;
	logic [7:0]           timeout_q;

	logic       accept;
	logic       out_free;
	logic       go;
	logic       is_pkt;
	logic       done;
	logic       produce;
	logic [7:0] pkt_byte;
	logic       pkt_last;
	rep_ctl_t   rep_ctl;
	rep_res_t   rep_res;

	sbpm_tx u_tx (
		.item      (item_q),
		.idx       (idx_q),
		.tx_byte   (pkt_byte),
		.last_byte (pkt_last)
	);

	sbpm_reply #(
		.REPLY_STORE_DEPTH(REPLY_STORE_DEPTH)
	) u_reply (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (rep_ctl),
		.rx_byte    (item_q.rx_byte),
		.timeout_ms (timeout_q),
		.res        (rep_res)
	);

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		go       = item_valid_q && out_free;
		is_pkt   = (item_q.command == CMD_LED) || (item_q.command == CMD_MOVE) ||
			(item_q.command == CMD_TORQUE) || (item_q.command == CMD_READ);
		done     = !is_pkt || pkt_last;
		in_stall = item_valid_q && !(go && done);
		accept   = in_valid && !in_stall;

		rep_ctl.start   = go && is_pkt && pkt_last;
		rep_ctl.is_read = (item_q.command == CMD_READ);
		rep_ctl.rx_en   = go && (item_q.command == CMD_RX);
		rep_ctl.tick_en = go && (item_q.command == CMD_TICK);
		produce = is_pkt || rep_res.report;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= '{command: command, servo_id: servo_id,
				target_position: target_position, move_speed: move_speed,
				state_value: state_value, rx_byte: rx_byte};
		end
		if (go && produce) begin
			if (is_pkt) begin
				res_q <= '{result_kind: KIND_TX, tx_byte: pkt_byte, last_byte: pkt_last,
					reply_status: 1'b0, error_byte: 8'd0, present_position: 16'd0};
			end else begin
				res_q <= '{result_kind: KIND_REPORT, tx_byte: 8'd0, last_byte: 1'b0,
					reply_status: rep_res.status, error_byte: rep_res.error_byte,
					present_position: rep_res.present_position};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			timeout_q    <= TIMEOUT_RESET;
		end else begin
			if (accept) begin
				item_valid_q <= 1'b1;
			end else if (go && done) begin
				item_valid_q <= 1'b0;
			end
			if (go) begin
				idx_q <= done ? '0 : idx_q + PKT_IDX_W'(1);
			end
			if (go && produce) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				timeout_q <= timeout_ms;
			end
		end
	end

	assign cfg_ready        = 1'b1;
	assign out_valid        = out_valid_q;
	assign result_kind      = res_q.result_kind;
	assign tx_byte          = res_q.tx_byte;
	assign last_byte        = res_q.last_byte;
	assign reply_status     = res_q.reply_status;
	assign error_byte       = res_q.error_byte;
	assign present_position = res_q.present_position;

endmodule

`default_nettype wire

/* sv/sbpm_tx.sv */
// Packet byte generator: byte and end mark for a command at a given byte index.
`default_nettype none

module sbpm_tx
	import sbpm_pkg::*;
(
	input  item_t                item,
	input  logic [PKT_IDX_W-1:0] idx,
	output logic [7:0]           tx_byte,
	output logic                 last_byte
);

	logic [7:0]           len_b;
	logic [7:0]           instr_b;
	logic [7:0]           reg_b;
	logic [7:0]           p0;
	logic [7:0]           p1;
	logic [7:0]           p2;
	logic [7:0]           p3;
	logic [7:0]           chk;
	logic [PKT_IDX_W-1:0] last_idx;

	always_comb begin
		len_b    = LEN_SHORT;
		instr_b  = INSTR_WRITE;
		reg_b    = REG_LED;
		p0       = item.state_value;
		p1       = 8'd0;
		p2       = 8'd0;
		p3       = 8'd0;
		last_idx = PKT_SHORT_LAST;
		case (item.command)
			CMD_LED: begin
				reg_b = REG_LED;
			end
			CMD_TORQUE: begin
				reg_b = REG_TORQUE;
			end
			CMD_MOVE: begin
				len_b    = LEN_MOVE;
				reg_b    = REG_GOAL;
				p0       = item.target_position[7:0];
				p1       = item.target_position[15:8];
				p2       = item.move_speed[7:0];
				p3       = item.move_speed[15:8];
				last_idx = PKT_MOVE_LAST;
			end
			CMD_READ: begin
				instr_b = INSTR_READ;
				reg_b   = REG_PRESENT;
				p0      = READ_SIZE;
			end
			default: begin
				reg_b = REG_LED;
			end
		endcase
		chk = ~(item.servo_id + len_b + instr_b + reg_b + p0 + p1 + p2 + p3);

		last_byte = (idx == last_idx);
		if (last_byte) begin
			tx_byte = chk;
		end else begin
			case (idx)
				4'd0:    tx_byte = START_BYTE;
				4'd1:    tx_byte = START_BYTE;
				4'd2:    tx_byte = item.servo_id;
				4'd3:    tx_byte = len_b;
				4'd4:    tx_byte = instr_b;
				4'd5:    tx_byte = reg_b;
				4'd6:    tx_byte = p0;
				4'd7:    tx_byte = p1;
				4'd8:    tx_byte = p2;
				4'd9:    tx_byte = p3;
				default: tx_byte = chk;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/sbpm_reply.sv */
// Reply tracker: reply store, byte count, tick timeout and completion report.
`default_nettype none

module sbpm_reply
	import sbpm_pkg::*;
#(
	parameter int REPLY_STORE_DEPTH = REPLY_STORE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  rep_ctl_t   ctl,
	input  logic [7:0] rx_byte,
	input  logic [7:0] timeout_ms,
	output rep_res_t   res
);

	localparam int CNT_W = $clog2(REPLY_STORE_DEPTH + 1);
	localparam int IDX_W = $clog2(REPLY_STORE_DEPTH);
	localparam int VIEW_N = READ_REPLY_LEN;

	logic [7:0]       store_q [REPLY_STORE_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic             awaiting_q;
	logic             is_read_q;
	logic [8:0]       tick_q;

	logic [CNT_W-1:0] need;
	logic             store_en;
	logic [CNT_W-1:0] count_next;
	logic             complete;
	logic [7:0]       view [VIEW_N];
	logic             start_ok;
	logic [8:0]       tick_next;
	logic             tick_fail;

	always_comb begin
		need = is_read_q ? CNT_W'(READ_REPLY_LEN) : CNT_W'(WRITE_REPLY_LEN);
		store_en = ctl.rx_en && awaiting_q && (count_q < need) &&
			(count_q < CNT_W'(REPLY_STORE_DEPTH));
		count_next = store_en ? count_q + CNT_W'(1) : count_q;
		complete = ctl.rx_en && awaiting_q && (count_next >= need);
		for (int j = 0; j < VIEW_N; j++) begin
			view[j] = (store_en && count_q == CNT_W'(j)) ? rx_byte : store_q[j];
		end
		start_ok = (view[0] == START_BYTE);
		tick_next = (tick_q < TICK_MAX) ? tick_q + 9'd1 : tick_q;
		tick_fail = ctl.tick_en && awaiting_q && (tick_next > {1'b0, timeout_ms});

		res.report           = complete || tick_fail;
		res.status           = tick_fail || !start_ok;
		res.error_byte       = 8'd0;
		res.present_position = 16'd0;
		if (complete && start_ok) begin
			res.error_byte = view[4];
			if (is_read_q) begin
				res.present_position = {view[6], view[5]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			store_q[count_q[IDX_W-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			awaiting_q <= 1'b0;
			is_read_q  <= 1'b0;
			tick_q     <= '0;
		end else if (ctl.start) begin
			count_q    <= '0;
			awaiting_q <= 1'b1;
			is_read_q  <= ctl.is_read;
			tick_q     <= '0;
		end else if (ctl.rx_en && awaiting_q) begin
			count_q <= count_next;
			if (complete) begin
				awaiting_q <= 1'b0;
			end
		end else if (ctl.tick_en && awaiting_q) begin
			tick_q <= tick_next;
			if (tick_fail) begin
				awaiting_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/sbpm_checker.sv */
// Port-level checks of the servo bus packet master, bound to the top level.
`default_nettype none

module sbpm_checker
	import sbpm_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        result_kind,
	input logic [7:0]  tx_byte,
	input logic        last_byte,
	input logic        reply_status,
	input logic [7:0]  error_byte,
	input logic [15:0] present_position
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(result_kind))
		else $error("stalled output word changed");

	a_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_REPORT |-> tx_byte == 8'd0 && !last_byte)
		else $error("report word carries transmit fields");

	a_tx_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_TX |->
			!reply_status && error_byte == 8'd0 && present_position == 16'd0)
		else $error("transmit word carries report fields");

	a_pkt_runs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && result_kind == KIND_TX && !last_byte |=>
			out_valid && result_kind == KIND_TX)
		else $error("packet broken before its checksum word");

endmodule

bind servo_bus_packet_master sbpm_checker u_sbpm_checker (.*);

`default_nettype wire
